FILE: sv/ipgs_pkg.sv
package ipgs_pkg;

  // default build values
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_SAMPLE_BITS  = 16;

  // arctangent table has this many entries
  localparam int ATAN_ENTRIES = 24;

  // control from the sequencer to each divide-by-five lane
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // atan(2^-i) in 0.01 degree units with 16 fraction bits
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd294912000;
      5'd1:    v = 32'd174096719;
      5'd2:    v = 32'd91987925;
      5'd3:    v = 32'd46694507;
      5'd4:    v = 32'd23437865;
      5'd5:    v = 32'd11730358;
      5'd6:    v = 32'd5866610;
      5'd7:    v = 32'd2933484;
      5'd8:    v = 32'd1466764;
      5'd9:    v = 32'd733385;
      5'd10:   v = 32'd366693;
      5'd11:   v = 32'd183347;
      5'd12:   v = 32'd91673;
      5'd13:   v = 32'd45837;
      5'd14:   v = 32'd22918;
      5'd15:   v = 32'd11459;
      5'd16:   v = 32'd5730;
      5'd17:   v = 32'd2865;
      5'd18:   v = 32'd1432;
      5'd19:   v = 32'd716;
      5'd20:   v = 32'd358;
      5'd21:   v = 32'd179;
      5'd22:   v = 32'd90;
      5'd23:   v = 32'd45;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/ipgs_div5.sv
// unsigned divide by five by reciprocal multiplication, exact for any W-bit dividend
module ipgs_div5
  import ipgs_pkg::*;
#(
  parameter int W = 26
) (
  input  logic         clk,
  input  div_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  output logic [W-1:0] quotient
);

  // reciprocal of five scaled by 2^(W+3), rounded up; the error stays below one step
  localparam int         K     = W + 3;
  localparam logic [W:0] RECIP = (W + 1)'(((64'd1 << K) + 64'd4) / 64'd5);

  logic [W-1:0] num_r;
  logic [W-1:0] q;
  logic [2*W:0] prod;

  // one multiply by the reciprocal
  assign prod = (2 * W + 1)'(num_r) * (2 * W + 1)'(RECIP);

  // load captures the dividend, step registers the quotient
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num_r <= dividend;
    end else if (ctl.step) begin
      q <= {2'b00, prod[2*W:K]};
    end
  end

  assign quotient = q;

endmodule

FILE: sv/imu_pitch_and_gyro_smoothing.sv
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   gyro_x..z, accel_x..z
// out      from block out_valid / out_stall avg_gyro_x..z, pitch_centideg
//
// the square root yields one result bit per cycle, then the CORDIC rotates once
// per cycle through one shared shift-and-add unit.
// the gyro averages divide by five by reciprocal multiplication before the root.
// rst (synchronous) clears the averages and the handshake state.
// in_stall is high from accept until the result moves into the output register;
// a result waiting on out_stall does not block the next accept.
module imu_pitch_and_gyro_smoothing
  import ipgs_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] gyro_x,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            avg_gyro_x,
  output logic signed [15:0]            avg_gyro_y,
  output logic signed [15:0]            avg_gyro_z,
  output logic signed [14:0]            pitch_centideg
);

  localparam int SB        = SAMPLE_BITS;
  localparam int STEPS     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int AW        = SB + 8;
  localparam int NW        = SB + 11;
  localparam int DIV_W     = SB + 10;
  localparam int R         = SB + 8;
  localparam int SQW       = 2 * SB;
  localparam int RADW      = 2 * R;
  localparam int CW        = SB + 11;
  localparam int ZW        = 32;
  localparam int CNT_MAX   = (R > STEPS) ? R : STEPS;
  localparam int CNT_W     = $clog2(CNT_MAX);

  localparam logic signed [SB:0] AVG_HI = (SB + 1)'((1 <<< (SB - 1)) - 1);
  localparam logic signed [SB:0] AVG_LO = -AVG_HI - (SB + 1)'(1);
  localparam logic signed [15:0] PITCH_LIM = 16'sd9000;

  typedef enum logic [2:0] {
    IDLE,
    MUL_A,
    MUL_B,
    SUM,
    ROOT,
    ROT,
    FIN
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;

  logic signed [SB-1:0] ax_r;
  logic signed [SB-1:0] ay_r;
  logic signed [SB-1:0] az_r;
  logic                 is_zero;

  logic signed [SB-1:0] gyro_in [3];
  logic signed [AW-1:0] avg     [3];
  logic signed [NW-1:0] num     [3];
  logic        [NW-1:0] mag     [3];
  logic     [DIV_W-1:0] div_in  [3];
  logic     [DIV_W-1:0] div_q   [3];
  logic signed [AW-1:0] avg_new [3];
  div_ctl_t             div_ctl;

  logic        [SQW-1:0]  prod;
  logic        [SQW-1:0]  sq;
  logic signed [SB-1:0]   mul_a;
  logic signed [SQW-1:0]  mul_p;

  logic [RADW-1:0] rad;
  logic [R+1:0]    rem;
  logic [R-1:0]    root;
  logic [R+1:0]    rem_t;
  logic [R+1:0]    trial;
  logic            root_ge;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;

  logic signed [ZW-1:0] z_half;
  logic signed [15:0]   z_round;
  logic signed [15:0]   z_sat;

  assign gyro_in[0] = gyro_x;
  assign gyro_in[1] = gyro_y;
  assign gyro_in[2] = gyro_z;

  // average lanes: |4*old + 256*new| + 2, divided by five, sign restored
  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign mag[g]     = num[g][NW-1] ? $unsigned(-num[g]) : $unsigned(num[g]);
    assign div_in[g]  = DIV_W'(mag[g]) + DIV_W'(2);
    assign avg_new[g] = num[g][NW-1] ? -$signed(AW'(div_q[g])) : $signed(AW'(div_q[g]));

    ipgs_div5 #(
      .W(DIV_W)
    ) u_div (
      .clk      (clk),
      .ctl      (div_ctl),
      .dividend (div_in[g]),
      .quotient (div_q[g])
    );
  end

  assign div_ctl.load = (state == MUL_A);
  assign div_ctl.step = (state == SUM);

  // shared squarer
  assign mul_a = (state == MUL_A) ? ay_r : az_r;
  assign mul_p = SQW'(mul_a) * SQW'(mul_a);

  // one bit of the integer square root
  always_comb begin
    rem_t   = {rem[R-1:0], rad[RADW-1 -: 2]};
    trial   = {root, 2'b01};
    root_ge = (rem_t >= trial);
  end

  // one CORDIC rotation through the shared shifter and adders
  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = $signed(atan_entry(5'(cnt)));
  end

  // final angle rounding and limiting
  always_comb begin
    z_half  = z + ZW'(32768);
    z_round = $signed(z_half[ZW-1:16]);
    if (z_round > PITCH_LIM) begin
      z_sat = PITCH_LIM;
    end else if (z_round < -PITCH_LIM) begin
      z_sat = -PITCH_LIM;
    end else begin
      z_sat = z_round;
    end
  end

  // average rounded to whole counts, limited to the sample range
  function automatic logic signed [15:0] round_avg(input logic signed [AW-1:0] a);
    logic [AW:0]        t;
    logic signed [SB:0] v;
    logic signed [SB:0] s;
    t = {a[AW-1], a} + (AW + 1)'(128);
    v = $signed(t[AW:8]);
    if (v > AVG_HI) begin
      s = AVG_HI;
    end else if (v < AVG_LO) begin
      s = AVG_LO;
    end else begin
      s = v;
    end
    return 16'(s);
  endfunction

  assign in_stall = (state != IDLE);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        avg[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 3; i++) begin
              num[i] <= (NW'(avg[i]) <<< 2) + (NW'(gyro_in[i]) <<< 8);
            end
            ax_r    <= accel_x;
            ay_r    <= accel_y;
            az_r    <= accel_z;
            is_zero <= (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
            state   <= MUL_A;
          end
        end
        MUL_A: begin
          prod  <= $unsigned(mul_p);
          state <= MUL_B;
        end
        MUL_B: begin
          prod  <= $unsigned(mul_p);
          sq    <= prod;
          state <= SUM;
        end
        SUM: begin
          rad   <= {SQW'(sq + prod), 16'b0};
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= ROOT;
        end
        ROOT: begin
          rad  <= rad << 2;
          rem  <= root_ge ? (rem_t - trial) : rem_t;
          root <= {root[R-2:0], root_ge};
          if (cnt == CNT_W'(R - 1)) begin
            // root done after this bit; quotients finished earlier
            x     <= $signed(CW'({root[R-2:0], root_ge}));
            y     <= -(CW'(ax_r) <<< 8);
            z     <= '0;
            cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
              avg[i] <= avg_new[i];
            end
            state <= ROT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ROT: begin
          if (!y[CW-1]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= FIN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        FIN: begin
          if (!out_valid || !out_stall) begin
            avg_gyro_x     <= round_avg(avg[0]);
            avg_gyro_y     <= round_avg(avg[1]);
            avg_gyro_z     <= round_avg(avg[2]);
            pitch_centideg <= is_zero ? '0 : 15'(z_sat);
            out_valid      <= 1'b1;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting an item");

  // a new result only comes out of the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == FIN)
    else $error("result appeared outside the final state");

  // pitch stays within the limited range
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_centideg <= 15'sd9000) && (pitch_centideg >= -15'sd9000))
    else $error("pitch outside limits");

  // the output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pitch_centideg) && $stable(avg_gyro_x))
    else $error("waiting result overwritten");

endmodule

FILE: bench/ipgs_checker.sv
`timescale 1ns / 1ps

module ipgs_checker
  import ipgs_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [DEF_SAMPLE_BITS-1:0] gyro_x,
  input  logic signed [DEF_SAMPLE_BITS-1:0] gyro_y,
  input  logic signed [DEF_SAMPLE_BITS-1:0] gyro_z,
  input  logic signed [DEF_SAMPLE_BITS-1:0] accel_x,
  input  logic signed [DEF_SAMPLE_BITS-1:0] accel_y,
  input  logic signed [DEF_SAMPLE_BITS-1:0] accel_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [15:0]                avg_gyro_x,
  input  logic signed [15:0]                avg_gyro_y,
  input  logic signed [15:0]                avg_gyro_z,
  input  logic signed [14:0]                pitch_centideg,
  input  logic                              drain_done,
  output int                                errors,
  output int                                backlog,
  output int                                samples_seen,
  output int                                results_seen,
  output int                                pitch_at_limit
);

  localparam int SB        = DEF_SAMPLE_BITS;
  localparam int ROT_STEPS = (DEF_CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : DEF_CORDIC_STEPS;
  localparam longint PITCH_LIMIT = 9000;

  typedef struct {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [14:0] pitch;
  } imu_result_t;

  imu_result_t          imu_results_q [$];
  logic signed [SB+7:0] rate_avg_x;
  logic signed [SB+7:0] rate_avg_y;
  logic signed [SB+7:0] rate_avg_z;
  logic                 leftovers_checked;

  // atan(2^-i), hundredths of a degree with 16 fraction bits
  function automatic longint arc_step(int i);
    case (i)
      0:       return 294912000;
      1:       return 174096719;
      2:       return 91987925;
      3:       return 46694507;
      4:       return 23437865;
      5:       return 11730358;
      6:       return 5866610;
      7:       return 2933484;
      8:       return 1466764;
      9:       return 733385;
      10:      return 366693;
      11:      return 183347;
      12:      return 91673;
      13:      return 45837;
      14:      return 22918;
      15:      return 11459;
      16:      return 5730;
      17:      return 2865;
      18:      return 1432;
      19:      return 716;
      20:      return 358;
      21:      return 179;
      22:      return 90;
      23:      return 45;
      default: return 0;
    endcase
  endfunction

  // (4*old + 256*rate) / 5, rounded to nearest, ties impossible
  function automatic longint smooth_step(longint old, longint rate);
    longint num;
    num = 4 * old + rate * 256;
    if (num >= 0) return (num + 2) / 5;
    return -((-num + 2) / 5);
  endfunction

  // drop the 8 fraction bits with half up, then clamp to the sample range
  function automatic logic signed [15:0] whole_counts(longint acc);
    longint v;
    longint lim;
    lim = (longint'(1) << (SB - 1)) - 1;
    v = (acc + 128) >>> 8;
    if (v > lim) v = lim;
    if (v < -lim - 1) v = -lim - 1;
    return v[15:0];
  endfunction

  // floor square root, two bits per pass
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = longint'(1) << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // atan2(-ax, |(ay, az)|) by vectoring rotations, in hundredths of a degree
  function automatic logic signed [14:0] tilt_centideg(longint ax, longint ay, longint az);
    longint unsigned sq;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint v;
    sq = ay * ay + az * az;
    if (ax == 0 && sq == 0) return '0;
    x = longint'(root_floor(sq << 16));
    y = -ax * 256;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arc_step(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arc_step(i);
      end
    end
    v = (z + 32768) >>> 16;
    if (v > PITCH_LIMIT) v = PITCH_LIMIT;
    if (v < -PITCH_LIMIT) v = -PITCH_LIMIT;
    return v[14:0];
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // watch both channels, predict on each accepted sample, compare on each result
  always @(posedge clk) begin
    imu_result_t want;
    imu_result_t next_r;
    longint      nx;
    longint      ny;
    longint      nz;
    if (rst) begin
      imu_results_q.delete();
      rate_avg_x        = '0;
      rate_avg_y        = '0;
      rate_avg_z        = '0;
      leftovers_checked = 1'b0;
      errors            = 0;
      samples_seen      = 0;
      results_seen      = 0;
      pitch_at_limit    = 0;
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        results_seen++;
        if (imu_results_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no sample pending", results_seen));
        end else begin
          want = imu_results_q.pop_front();
          if (avg_gyro_x !== want.gx)
            flag_mismatch($sformatf("result %0d avg_gyro_x: got %0d, expected %0d",
                                    results_seen, avg_gyro_x, want.gx));
          if (avg_gyro_y !== want.gy)
            flag_mismatch($sformatf("result %0d avg_gyro_y: got %0d, expected %0d",
                                    results_seen, avg_gyro_y, want.gy));
          if (avg_gyro_z !== want.gz)
            flag_mismatch($sformatf("result %0d avg_gyro_z: got %0d, expected %0d",
                                    results_seen, avg_gyro_z, want.gz));
          if (pitch_centideg !== want.pitch)
            flag_mismatch($sformatf("result %0d pitch_centideg: got %0d, expected %0d",
                                    results_seen, pitch_centideg, want.pitch));
        end
      end
      // sample side: update the running averages and queue the prediction
      if (in_valid && !in_stall) begin
        samples_seen++;
        nx = smooth_step(rate_avg_x, gyro_x);
        ny = smooth_step(rate_avg_y, gyro_y);
        nz = smooth_step(rate_avg_z, gyro_z);
        rate_avg_x   = nx[SB+7:0];
        rate_avg_y   = ny[SB+7:0];
        rate_avg_z   = nz[SB+7:0];
        next_r.gx    = whole_counts(nx);
        next_r.gy    = whole_counts(ny);
        next_r.gz    = whole_counts(nz);
        next_r.pitch = tilt_centideg(accel_x, accel_y, accel_z);
        if (next_r.pitch == PITCH_LIMIT || next_r.pitch == -PITCH_LIMIT) pitch_at_limit++;
        imu_results_q.push_back(next_r);
      end
      // nothing may stay pending once the run has drained
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (imu_results_q.size() != 0)
          flag_mismatch($sformatf("%0d predicted results never arrived", imu_results_q.size()));
      end
    end
    backlog = imu_results_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ipgs_pkg::*;

  localparam int SB           = DEF_SAMPLE_BITS;
  localparam int SAMPLE_COUNT = 650;
  localparam int QUIET_FROM   = 560;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 500000;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 out_stall  = 1'b0;
  logic                 drain_done = 1'b0;
  logic                 quiet      = 1'b0;
  logic signed [SB-1:0] gyro_x     = '0;
  logic signed [SB-1:0] gyro_y     = '0;
  logic signed [SB-1:0] gyro_z     = '0;
  logic signed [SB-1:0] accel_x    = '0;
  logic signed [SB-1:0] accel_y    = '0;
  logic signed [SB-1:0] accel_z    = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [15:0]   avg_gyro_x;
  logic signed [15:0]   avg_gyro_y;
  logic signed [15:0]   avg_gyro_z;
  logic signed [14:0]   pitch_centideg;
  int                   errors;
  int                   backlog;
  int                   samples_seen;
  int                   results_seen;
  int                   pitch_at_limit;
  int                   cycles     = 0;

  always #5 clk = ~clk;

  imu_pitch_and_gyro_smoothing u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .gyro_x         (gyro_x),
    .gyro_y         (gyro_y),
    .gyro_z         (gyro_z),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .avg_gyro_x     (avg_gyro_x),
    .avg_gyro_y     (avg_gyro_y),
    .avg_gyro_z     (avg_gyro_z),
    .pitch_centideg (pitch_centideg)
  );

  ipgs_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .gyro_x         (gyro_x),
    .gyro_y         (gyro_y),
    .gyro_z         (gyro_z),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .avg_gyro_x     (avg_gyro_x),
    .avg_gyro_y     (avg_gyro_y),
    .avg_gyro_z     (avg_gyro_z),
    .pitch_centideg (pitch_centideg),
    .drain_done     (drain_done),
    .errors         (errors),
    .backlog        (backlog),
    .samples_seen   (samples_seen),
    .results_seen   (results_seen),
    .pitch_at_limit (pitch_at_limit)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("imu_pitch_and_gyro_smoothing: mismatch");
      $finish;
    end
  end

  // receiver backpressure in random bursts, off once the run goes quiet
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [SB-1:0] pick_signed(int span);
    return SB'($urandom_range(0, 2 * span) - span);
  endfunction

  // full-scale corners with some random filler
  function automatic logic [SB-1:0] pick_corner();
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(SB-1){1'b0}}};
      1:       return {1'b0, {(SB-1){1'b1}}};
      2:       return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  // present one item, optionally after an idle gap, and hold it until accepted
  task automatic send_sample(input logic [SB-1:0] gx, input logic [SB-1:0] gy,
                             input logic [SB-1:0] gz, input logic [SB-1:0] ax,
                             input logic [SB-1:0] ay, input logic [SB-1:0] az);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    gyro_x   <= gx;
    gyro_y   <= gy;
    gyro_z   <= gz;
    accel_x  <= ax;
    accel_y  <= ay;
    accel_z  <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [SB-1:0] gx;
    logic [SB-1:0] gy;
    logic [SB-1:0] gz;
    logic [SB-1:0] ax;
    logic [SB-1:0] ay;
    logic [SB-1:0] az;
    int            mode;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: zero tilt, straight up and down, 45 degree cases, field extremes
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0, 0);
    repeat (4) send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0);
    repeat (5) send_sample(16'h8000, 16'h8000, 16'h8000, 0, 8192, 0);
    send_sample(1, -1, 0, 8192, 0, 8192);
    send_sample(-1, 1, 0, -8192, 0, -8192);
    send_sample(16'h8000, 16'h7fff, 0, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000, 1, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(0, 0, 0, 1, 0, 0);
    send_sample(0, 0, 0, 0, 0, 1);
    send_sample(0, 0, 0, -1, 1, 0);
    send_sample(3, -3, 2, 0, 0, 0);
    send_sample(-2, 2, -3, 16'h8000, 16'h7fff, 0);

    // random: mostly plausible motion, plus full-range noise and corners
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: begin
          gx = pick_signed(2000);
          gy = pick_signed(2000);
          gz = pick_signed(2000);
          ax = pick_signed(12000);
          ay = pick_signed(12000);
          az = pick_signed(12000);
        end
        4, 5: begin
          gx = SB'($urandom);
          gy = SB'($urandom);
          gz = SB'($urandom);
          ax = SB'($urandom);
          ay = SB'($urandom);
          az = SB'($urandom);
        end
        6: begin
          gx = SB'($urandom);
          gy = SB'($urandom);
          gz = SB'($urandom);
          ax = SB'($urandom);
          ay = $urandom_range(0, 1) ? '0 : SB'($urandom);
          az = $urandom_range(0, 1) ? '0 : SB'($urandom);
        end
        7: begin
          gx = SB'($urandom);
          gy = SB'($urandom);
          gz = SB'($urandom);
          ax = '0;
          ay = '0;
          az = '0;
        end
        8: begin
          gx = pick_corner();
          gy = pick_corner();
          gz = pick_corner();
          ax = pick_corner();
          ay = pick_corner();
          az = pick_corner();
        end
        default: begin
          gx = pick_signed(3);
          gy = pick_signed(3);
          gz = pick_signed(3);
          ax = pick_signed(3);
          ay = pick_signed(3);
          az = pick_signed(3);
        end
      endcase
      send_sample(gx, gy, gz, ax, ay, az);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, let the pipeline settle, then check for leftovers
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("sent %0d samples and compared %0d results", samples_seen, results_seen);
    $display("%0d predicted pitches sat at the +/-90 degree limit", pitch_at_limit);
    if (errors == 0) begin
      $display("imu_pitch_and_gyro_smoothing: match");
    end else begin
      $display("imu_pitch_and_gyro_smoothing: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ipgs_pkg.sv
sv/ipgs_div5.sv
sv/imu_pitch_and_gyro_smoothing.sv
bench/ipgs_checker.sv
bench/tb.sv
